FILE: hw/rtl/mmbp_pkg.sv
// ----------------------------------------------------------------------------
// Multi-mode branch predictor package
// Shared constants, the operation word passed from the front to the back,
// and the saturating counter step.
// ----------------------------------------------------------------------------
package mmbp_pkg;

    localparam int KIND_W        = 3;
    localparam int HIST_W        = 8;
    localparam int CTR_W         = 2;
    localparam int ADDR_W        = 32;
    localparam int WADDR_W       = 30;
    localparam int BIM_IDX_W_MAX = 16;
    localparam int PAT_IDX_W_MAX = 24;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = 2;
    localparam int QCNT_W        = 3;

    localparam logic [KIND_W-1:0] KIND_TAKEN     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NOT_TAKEN = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BIMODAL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TWO_LEVEL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GSHARE    = 3'd4;

    localparam logic [CTR_W-1:0] CTR_MIN   = 2'd0;
    localparam logic [CTR_W-1:0] CTR_RESET = 2'd1;
    localparam logic [CTR_W-1:0] CTR_MAX   = 2'd3;

    typedef enum logic [2:0] {
        OP_PRED_TAKEN,
        OP_PRED_NOT_TAKEN,
        OP_PRED_BIM,
        OP_PRED_PAT,
        OP_UPD_BIM,
        OP_UPD_PAT,
        OP_UPD_BOTH
    } op_kind_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic                     taken;
        logic [BIM_IDX_W_MAX-1:0] bim_idx;
        logic [PAT_IDX_W_MAX-1:0] pat_idx;
    } op_t;

    function automatic logic [CTR_W-1:0] ctr_move(input logic [CTR_W-1:0] c, input logic up);
        logic [CTR_W-1:0] n;
        if (up)
        begin
            n = (c == CTR_MAX) ? c : c + 2'd1;
        end
        else
        begin
            n = (c == CTR_MIN) ? c : c - 2'd1;
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/mmbp_rem.sv
// ----------------------------------------------------------------------------
// Remainder unit
// Reduces an unsigned value modulo a constant. Powers of two and divisors
// above the input range reduce by masking. For other divisors a reciprocal
// multiplication gives the quotient, registered with the value, then the
// quotient times the divisor is subtracted from the value into a register.
// ----------------------------------------------------------------------------
module mmbp_rem #(
    parameter int W  = 8,
    parameter int N  = 2,
    parameter int RW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic [W-1:0]  x,
    output logic          done,
    output logic [RW-1:0] r
);

    localparam bit DIRECT = ((N & (N - 1)) == 0) || (N >= 2 ** W);

    generate
        if (DIRECT)
        begin : g_direct
            localparam logic [W-1:0] MASK = (N >= 2 ** W) ? {W{1'b1}} : W'(N - 1);

            assign r    = RW'(x & MASK);
            assign done = 1'b1;
        end
        else
        begin : g_recip
            localparam int L  = $clog2(N);
            localparam int S  = W + L;
            localparam int MW = W + 1;
            localparam int PW = W + MW;
            localparam logic [MW-1:0] RECIP =
                MW'(((64'd1 << S) + 64'(N) - 64'd1) / 64'(N));
            localparam logic [W-1:0] DIV = W'(N);

            logic [W-1:0]  x_reg;
            logic [W-1:0]  quo_reg;
            logic [RW-1:0] r_reg;
            logic          step_reg;
            logic [PW-1:0] prod;
            logic [W-1:0]  rem_full;

            always_comb
            begin
                prod     = PW'(x) * PW'(RECIP);
                rem_full = x_reg - quo_reg * DIV;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= load;
                end
            end

            always_ff @(posedge clk)
            begin
                if (load)
                begin
                    x_reg   <= x;
                    quo_reg <= W'(prod >> S);
                end
                if (step_reg)
                begin
                    r_reg <= RW'(rem_full);
                end
            end

            assign r    = r_reg;
            assign done = !step_reg && !load;
        end
    endgenerate

endmodule

FILE: hw/rtl/mmbp_front.sv
// ----------------------------------------------------------------------------
// Predictor front end
// Accepts commands, keeps the global history in command order, computes the
// table indices; commands but static-kind updates become back operation words.
// ----------------------------------------------------------------------------
module mmbp_front #(
    parameter int BIMODAL_ENTRIES = 256,
    parameter int PATTERN_ROWS    = 256,
    parameter int PATTERN_COLS    = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        mode,
    input  logic [mmbp_pkg::ADDR_W-1:0] branch_address,
    input  logic                        outcome_taken,
    input  logic [mmbp_pkg::KIND_W-1:0] kind,
    input  logic                        clearing,
    input  logic                        full,
    output logic                        busy,
    output logic                        push,
    output mmbp_pkg::op_t               op
);

    import mmbp_pkg::*;

    localparam int BW  = $clog2(BIMODAL_ENTRIES);
    localparam int PRW = $clog2(PATTERN_ROWS);
    localparam int CLW = (PATTERN_COLS > 1) ? $clog2(PATTERN_COLS) : 1;
    localparam int PIW = $clog2(PATTERN_ROWS * PATTERN_COLS);

    logic               item_valid_reg;
    logic               fresh_reg;
    logic               r3_started_reg;
    logic               mode_reg;
    logic               taken_reg;
    logic [WADDR_W-1:0] addr_reg;
    logic [HIST_W-1:0]  hist_snap_reg;
    logic [HIST_W-1:0]  hist_reg;

    logic               accept;
    logic               retire;
    logic               ready_item;
    logic               need_push;
    logic               r3_load;
    logic               slot_done;
    logic               col_done;
    logic               gsh_done;
    logic               r3_done;
    logic [BW-1:0]      slot_r;
    logic [CLW-1:0]     col_r;
    logic [PRW-1:0]     gsh_r;
    logic [PRW-1:0]     r3_r;
    logic [PRW-1:0]     row_sel;
    logic [CLW-1:0]     col_sel;
    logic [PIW-1:0]     pat_idx;

    mmbp_rem #(.W(WADDR_W), .N(BIMODAL_ENTRIES), .RW(BW)) u_slot (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fresh_reg),
        .x     (addr_reg),
        .done  (slot_done),
        .r     (slot_r)
    );

    mmbp_rem #(.W(HIST_W), .N(PATTERN_COLS), .RW(CLW)) u_col (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fresh_reg),
        .x     (hist_snap_reg),
        .done  (col_done),
        .r     (col_r)
    );

    mmbp_rem #(.W(WADDR_W), .N(PATTERN_ROWS), .RW(PRW)) u_gsh (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fresh_reg),
        .x     (addr_reg ^ WADDR_W'(hist_snap_reg)),
        .done  (gsh_done),
        .r     (gsh_r)
    );

    mmbp_rem #(.W(BW), .N(PATTERN_ROWS), .RW(PRW)) u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (r3_load),
        .x     (slot_r),
        .done  (r3_done),
        .r     (r3_r)
    );

    assign r3_load    = item_valid_reg && slot_done && !r3_started_reg;
    assign ready_item = item_valid_reg && slot_done && col_done && gsh_done && r3_done;
    assign push       = ready_item && need_push && !full;
    assign retire     = ready_item && (!need_push || !full);
    assign busy       = clearing || (item_valid_reg && !retire);
    assign accept     = start && !busy;

    always_comb
    begin
        if (kind == KIND_GSHARE)
        begin
            row_sel = gsh_r;
            col_sel = '0;
        end
        else
        begin
            row_sel = r3_r;
            col_sel = col_r;
        end
        pat_idx = PIW'(row_sel) * PIW'(PATTERN_COLS) + PIW'(col_sel);
    end

    always_comb
    begin
        op         = '0;
        op.kind    = OP_PRED_NOT_TAKEN;
        op.taken   = taken_reg;
        op.bim_idx = BIM_IDX_W_MAX'(slot_r);
        op.pat_idx = PAT_IDX_W_MAX'(pat_idx);
        need_push  = 1'b1;
        if (!mode_reg)
        begin
            unique case (kind)
                KIND_TAKEN:     op.kind = OP_PRED_TAKEN;
                KIND_BIMODAL:   op.kind = OP_PRED_BIM;
                KIND_TWO_LEVEL: op.kind = OP_PRED_PAT;
                KIND_GSHARE:    op.kind = OP_PRED_PAT;
                default:        op.kind = OP_PRED_NOT_TAKEN;
            endcase
        end
        else
        begin
            unique case (kind)
                KIND_BIMODAL:   op.kind = OP_UPD_BIM;
                KIND_TWO_LEVEL: op.kind = OP_UPD_BOTH;
                KIND_GSHARE:    op.kind = OP_UPD_PAT;
                default:        need_push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            fresh_reg      <= 1'b0;
            r3_started_reg <= 1'b0;
            hist_reg       <= '0;
        end
        else
        begin
            fresh_reg <= accept;
            if (accept)
            begin
                item_valid_reg <= 1'b1;
                r3_started_reg <= 1'b0;
            end
            else
            begin
                if (retire)
                begin
                    item_valid_reg <= 1'b0;
                end
                if (r3_load)
                begin
                    r3_started_reg <= 1'b1;
                end
            end
            if (accept && mode)
            begin
                hist_reg <= {hist_reg[HIST_W-2:0], outcome_taken};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg      <= mode;
            taken_reg     <= outcome_taken;
            addr_reg      <= branch_address[ADDR_W-1:2];
            hist_snap_reg <= hist_reg;
        end
    end

endmodule

FILE: hw/rtl/mmbp_queue.sv
// ----------------------------------------------------------------------------
// Operation queue
// A short first-in first-out buffer of operation words between the front
// end and the table back end.
// ----------------------------------------------------------------------------
module mmbp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mmbp_pkg::op_t din,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output mmbp_pkg::op_t dout
);

    import mmbp_pkg::*;

    op_t               slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: hw/rtl/mmbp_back.sv
// ----------------------------------------------------------------------------
// Predictor back end
// Holds the bimodal and pattern counter tables, clears them after reset and
// runs each operation as a registered read, then a write back for updates.
// ----------------------------------------------------------------------------
module mmbp_back #(
    parameter int BIMODAL_ENTRIES = 256,
    parameter int PATTERN_ROWS    = 256,
    parameter int PATTERN_COLS    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  mmbp_pkg::op_t op,
    output logic          pop,
    output logic          clearing,
    output logic          result_valid,
    output logic          predict_taken
);

    import mmbp_pkg::*;

    localparam int BW      = $clog2(BIMODAL_ENTRIES);
    localparam int PAT_N   = PATTERN_ROWS * PATTERN_COLS;
    localparam int PIW     = $clog2(PAT_N);
    localparam int CLR_N   = (BIMODAL_ENTRIES > PAT_N) ? BIMODAL_ENTRIES : PAT_N;
    localparam int CNW     = $clog2(CLR_N);

    logic [CTR_W-1:0] bim_mem [BIMODAL_ENTRIES];
    logic [CTR_W-1:0] pat_mem [PAT_N];

    logic             clearing_reg;
    logic [CNW-1:0]   clr_cnt_reg;
    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic [CTR_W-1:0] bim_rd_reg;
    logic [CTR_W-1:0] pat_rd_reg;
    logic             bim_fwd_reg;
    logic             pat_fwd_reg;
    logic [CTR_W-1:0] bim_fwd_val_reg;
    logic [CTR_W-1:0] pat_fwd_val_reg;
    logic             result_valid_reg;
    logic             predict_taken_reg;

    logic [CTR_W-1:0] bim_cur;
    logic [CTR_W-1:0] pat_cur;
    logic [CTR_W-1:0] bim_new;
    logic [CTR_W-1:0] pat_new;
    logic             bim_we;
    logic             pat_we;
    logic             is_pred;
    logic             pred;
    logic [BW-1:0]    s1_bim_addr;
    logic [PIW-1:0]   s1_pat_addr;
    logic [BW-1:0]    rd_bim_addr;
    logic [PIW-1:0]   rd_pat_addr;

    assign clearing    = clearing_reg;
    assign pop         = !empty && !clearing_reg;
    assign s1_bim_addr = s1_op_reg.bim_idx[BW-1:0];
    assign s1_pat_addr = s1_op_reg.pat_idx[PIW-1:0];
    assign rd_bim_addr = op.bim_idx[BW-1:0];
    assign rd_pat_addr = op.pat_idx[PIW-1:0];

    always_comb
    begin
        bim_cur = bim_fwd_reg ? bim_fwd_val_reg : bim_rd_reg;
        pat_cur = pat_fwd_reg ? pat_fwd_val_reg : pat_rd_reg;
        bim_new = ctr_move(bim_cur, s1_op_reg.taken);
        pat_new = ctr_move(pat_cur, s1_op_reg.taken);
        bim_we  = 1'b0;
        pat_we  = 1'b0;
        is_pred = 1'b0;
        pred    = 1'b0;
        unique case (s1_op_reg.kind)
            OP_PRED_TAKEN:
            begin
                is_pred = 1'b1;
                pred    = 1'b1;
            end
            OP_PRED_NOT_TAKEN:
            begin
                is_pred = 1'b1;
            end
            OP_PRED_BIM:
            begin
                is_pred = 1'b1;
                pred    = bim_cur[CTR_W-1];
            end
            OP_PRED_PAT:
            begin
                is_pred = 1'b1;
                pred    = pat_cur[CTR_W-1];
            end
            OP_UPD_BIM:  bim_we = s1_valid_reg;
            OP_UPD_PAT:  pat_we = s1_valid_reg;
            OP_UPD_BOTH:
            begin
                bim_we = s1_valid_reg;
                pat_we = s1_valid_reg;
            end
            default:
            begin
                is_pred = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg     <= 1'b1;
            clr_cnt_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == CLR_N - 1)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            s1_valid_reg     <= pop;
            result_valid_reg <= s1_valid_reg && is_pred;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_op_reg       <= op;
            bim_fwd_reg     <= bim_we && (s1_bim_addr == rd_bim_addr);
            pat_fwd_reg     <= pat_we && (s1_pat_addr == rd_pat_addr);
            bim_fwd_val_reg <= bim_new;
            pat_fwd_val_reg <= pat_new;
        end
        predict_taken_reg <= pred;
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            if (32'(clr_cnt_reg) < BIMODAL_ENTRIES)
            begin
                bim_mem[clr_cnt_reg[BW-1:0]] <= CTR_RESET;
            end
        end
        else if (bim_we)
        begin
            bim_mem[s1_bim_addr] <= bim_new;
        end
        bim_rd_reg <= bim_mem[rd_bim_addr];
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            if (32'(clr_cnt_reg) < PAT_N)
            begin
                pat_mem[clr_cnt_reg[PIW-1:0]] <= CTR_RESET;
            end
        end
        else if (pat_we)
        begin
            pat_mem[s1_pat_addr] <= pat_new;
        end
        pat_rd_reg <= pat_mem[rd_pat_addr];
    end

    assign result_valid  = result_valid_reg;
    assign predict_taken = predict_taken_reg;

endmodule

FILE: hw/rtl/multi_mode_branch_predictor.sv
// ----------------------------------------------------------------------------
// Multi-mode branch predictor
// Always taken, always not taken, bimodal, two-level and gshare prediction
// with 2-bit saturating counters and an 8-bit global history.
//
//   Channel   Signals                                       Handshake
//   command   mode, branch_address, outcome_taken           start and not busy
//   result    predict_taken                                 result_valid, one cycle
//   config    cfg_wdata (predictor kind)                    cfg_we
//
// One command per cycle with power-of-two table sizes and room in the queue;
// other sizes hold busy for the front remainder units, the row unit starting
// once the bimodal slot is known. Predictions pass the front registers, queue,
// back read stage and result register. After reset, busy high, both tables
// clear one entry per cycle up to the larger of BIMODAL_ENTRIES and
// PATTERN_ROWS * PATTERN_COLS (4096 by default). Results cannot be stalled.
// ----------------------------------------------------------------------------
module multi_mode_branch_predictor #(
    parameter int BIMODAL_ENTRIES = 256,
    parameter int PATTERN_ROWS    = 256,
    parameter int PATTERN_COLS    = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        mode,
    input  logic [mmbp_pkg::ADDR_W-1:0] branch_address,
    input  logic                        outcome_taken,
    output logic                        result_valid,
    output logic                        predict_taken,
    input  logic                        cfg_we,
    input  logic [mmbp_pkg::KIND_W-1:0] cfg_wdata
);

    import mmbp_pkg::*;

    logic [KIND_W-1:0] kind_reg;
    logic              clearing;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    op_t               front_op;
    op_t               back_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_TAKEN;
        end
        else if (cfg_we)
        begin
            kind_reg <= cfg_wdata;
        end
    end

    mmbp_front #(
        .BIMODAL_ENTRIES (BIMODAL_ENTRIES),
        .PATTERN_ROWS    (PATTERN_ROWS),
        .PATTERN_COLS    (PATTERN_COLS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .mode           (mode),
        .branch_address (branch_address),
        .outcome_taken  (outcome_taken),
        .kind           (kind_reg),
        .clearing       (clearing),
        .full           (full),
        .busy           (busy),
        .push           (push),
        .op             (front_op)
    );

    mmbp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_op),
        .pop   (pop),
        .full  (full),
        .empty (empty),
        .dout  (back_op)
    );

    mmbp_back #(
        .BIMODAL_ENTRIES (BIMODAL_ENTRIES),
        .PATTERN_ROWS    (PATTERN_ROWS),
        .PATTERN_COLS    (PATTERN_COLS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .op            (back_op),
        .pop           (pop),
        .clearing      (clearing),
        .result_valid  (result_valid),
        .predict_taken (predict_taken)
    );

endmodule
